// File: design/uer_pkg.sv
package uer_pkg;

    // Register map, byte addresses
    localparam logic [2:0] ADDR_TRIGGER_EVERY = 3'd0;
    localparam logic [2:0] ADDR_TRIGGER_WIDTH = 3'd4;

    localparam logic [7:0]  TRIGGER_EVERY_RST = 8'd11;
    localparam logic [15:0] TRIGGER_WIDTH_RST = 16'd1000;

    localparam int unsigned RANGE_BITS = 14;

    // mm = width * 340 / 2000 = width * 17 / 100
    localparam int unsigned SCALE_NUM    = 17;
    localparam int unsigned SCALE_DEN    = 100;
    // floor(2^27 / 100); estimate is low by at most one for products below 2^21
    localparam int unsigned RECIP        = 1342177;
    localparam int unsigned RECIP_SHIFT  = 27;
    // smallest width whose distance exceeds the 14-bit range
    localparam int unsigned SAT_WIDTH    = 96377;
    localparam logic [RANGE_BITS-1:0] RANGE_MAX = 14'd16383;

    typedef logic [RANGE_BITS-1:0] range_t;

endpackage

// File: design/ultrasonic_echo_ranger_core.sv
// Two-channel ultrasonic echo ranger. Each accepted s_axis transaction is one
// 1 us tick carrying both echo levels and the frame tick; every tick yields
// exactly one m_axis transaction with the trigger level, a valid flag per
// channel and the last distance of each channel in millimetres (held between
// measurements, width * 340 / 2000 truncated, saturated at 16383). One tick is
// accepted per clock unless a result waits on m_axis_tready with the stage full.
// Edge detect works on the incoming tick and is captured in the stage register
// at the accepting edge; the mm scaling, whose reciprocal multiply sets the
// clock, sits between that register and the output register. The output
// register lets a new tick into the empty stage register while a result waits
// for m_axis_tready. Registers on APB: 0x0 trigger_every (frame ticks per
// trigger), 0x4 trigger_width (pulse length in ticks); pready is always high.
module ultrasonic_echo_ranger_core
    import uer_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] echo_a, [1] echo_b, [2] frame_tick
    input  logic [7:0]  s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] trigger_out, [1] range_a_valid, [15:2] range_a_mm,
    // [16] range_b_valid, [30:17] range_b_mm
    output logic [31:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

    function automatic range_t scale_mm(input logic [32:0] w);
        logic        sat;
        logic [20:0] x;
        logic [41:0] prod;
        logic [14:0] q;
        logic [20:0] rem;
        logic [14:0] qc;
        sat  = (w >= 33'(SAT_WIDTH));
        x    = 21'(w[16:0]) * 21'(SCALE_NUM);
        prod = 42'(x) * 42'(RECIP);
        q    = prod[RECIP_SHIFT +: 15];
        rem  = x - 21'(21'(q) * 21'(SCALE_DEN));
        qc   = (rem >= 21'(SCALE_DEN)) ? q + 15'd1 : q;
        return sat ? RANGE_MAX : qc[RANGE_BITS-1:0];
    endfunction

    // configuration
    logic [7:0]  trig_every_reg;
    logic [15:0] trig_width_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_every_reg <= TRIGGER_EVERY_RST;
            trig_width_reg <= TRIGGER_WIDTH_RST;
        end else if (cfg_wr) begin
            if (paddr == ADDR_TRIGGER_EVERY) begin
                trig_every_reg <= pwdata[7:0];
            end else if (paddr == ADDR_TRIGGER_WIDTH) begin
                trig_width_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_TRIGGER_EVERY: prdata = {24'd0, trig_every_reg};
            ADDR_TRIGGER_WIDTH: prdata = {16'd0, trig_width_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // handshake
    logic out_valid_reg;
    logic p1_valid_reg;
    logic out_free;
    logic in_acc;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !p1_valid_reg || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // stage 1: edge detect, timing state, trigger
    logic [COUNTER_BITS-1:0] tick_reg, tick_next;
    logic [COUNTER_BITS-1:0] start_a_reg, start_a_next;
    logic [COUNTER_BITS-1:0] start_b_reg, start_b_next;
    logic                    armed_a_reg, armed_a_next;
    logic                    armed_b_reg, armed_b_next;
    logic [1:0]              prev_echo_reg;
    logic [7:0]              frame_cnt_reg, frame_cnt_next;
    logic [15:0]             trig_left_reg, trig_left_next;
    logic                    done_a_next, done_b_next, trig_next;
    logic [8:0]              frame_inc;
    logic [15:0]             left_load;
    logic                    ea, eb, ft;

    assign ea = s_axis_tdata[0];
    assign eb = s_axis_tdata[1];
    assign ft = s_axis_tdata[2];

    always_comb begin
        start_a_next = start_a_reg;
        armed_a_next = armed_a_reg;
        done_a_next  = 1'b0;
        if (ea && !prev_echo_reg[0]) begin
            start_a_next = tick_reg;
            armed_a_next = 1'b1;
        end else if (!ea && prev_echo_reg[0] && armed_a_reg) begin
            armed_a_next = 1'b0;
            done_a_next  = 1'b1;
        end

        start_b_next = start_b_reg;
        armed_b_next = armed_b_reg;
        done_b_next  = 1'b0;
        if (eb && !prev_echo_reg[1]) begin
            start_b_next = tick_reg;
            armed_b_next = 1'b1;
        end else if (!eb && prev_echo_reg[1] && armed_b_reg) begin
            armed_b_next = 1'b0;
            done_b_next  = 1'b1;
        end

        frame_inc      = {1'b0, frame_cnt_reg} + 9'd1;
        frame_cnt_next = frame_cnt_reg;
        left_load      = trig_left_reg;
        if (ft) begin
            if (frame_inc >= {1'b0, trig_every_reg}) begin
                frame_cnt_next = 8'd0;
                left_load      = trig_width_reg;
            end else begin
                frame_cnt_next = frame_inc[7:0];
            end
        end
        // the pulse covers the loading tick itself
        trig_next      = (left_load != 16'd0);
        trig_left_next = trig_next ? left_load - 16'd1 : left_load;

        tick_next = tick_reg + CNT_ONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            start_a_reg   <= '0;
            start_b_reg   <= '0;
            armed_a_reg   <= 1'b0;
            armed_b_reg   <= 1'b0;
            prev_echo_reg <= 2'b00;
            frame_cnt_reg <= 8'd0;
            trig_left_reg <= 16'd0;
        end else if (in_acc) begin
            tick_reg      <= tick_next;
            start_a_reg   <= start_a_next;
            start_b_reg   <= start_b_next;
            armed_a_reg   <= armed_a_next;
            armed_b_reg   <= armed_b_next;
            prev_echo_reg <= {eb, ea};
            frame_cnt_reg <= frame_cnt_next;
            trig_left_reg <= trig_left_next;
        end
    end

    // stage 1 result register
    logic                    p1_trig_reg;
    logic                    p1_done_a_reg, p1_done_b_reg;
    logic [COUNTER_BITS-1:0] p1_width_a_reg, p1_width_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            p1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            p1_trig_reg    <= trig_next;
            p1_done_a_reg  <= done_a_next;
            p1_done_b_reg  <= done_b_next;
            p1_width_a_reg <= tick_reg - start_a_reg;
            p1_width_b_reg <= tick_reg - start_b_reg;
        end
    end

    // stage 2: scale to mm, hold last ranges
    range_t range_a_reg, range_b_reg;
    range_t mm_a, mm_b;
    logic   p2_adv;

    assign p2_adv = p1_valid_reg && out_free;
    assign mm_a   = p1_done_a_reg
                  ? scale_mm({{(33-COUNTER_BITS){1'b0}}, p1_width_a_reg}) : range_a_reg;
    assign mm_b   = p1_done_b_reg
                  ? scale_mm({{(33-COUNTER_BITS){1'b0}}, p1_width_b_reg}) : range_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            range_a_reg   <= '0;
            range_b_reg   <= '0;
        end else begin
            if (out_free) begin
                out_valid_reg <= p1_valid_reg;
            end
            if (p2_adv) begin
                range_a_reg <= mm_a;
                range_b_reg <= mm_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_adv) begin
            m_axis_tdata <= {1'b0, mm_b, p1_done_b_reg, mm_a, p1_done_a_reg, p1_trig_reg};
        end
    end

endmodule
